>>> rtl/hbfd_pkg.sv
// Package for the heartbeat failure detector: default sizes, status and
// register codes, and the configuration record. No dependencies.
`default_nettype none
package hbfd_pkg;

  localparam int HBFD_TABLE_DEPTH = 32;
  localparam int HBFD_KEY_BITS    = 16;
  localparam int HBFD_COUNT_BITS  = 32;

  localparam int CNT_W = 6;

  typedef logic [2:0] status_t;
  localparam status_t ST_STALE   = 3'd0;
  localparam status_t ST_REFRESH = 3'd1;
  localparam status_t ST_REVIVE  = 3'd2;
  localparam status_t ST_ADDED   = 3'd3;
  localparam status_t ST_FULL    = 3'd4;
  localparam status_t ST_TICK    = 3'd5;

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_ROUND   = 2'd0;
  localparam reg_idx_t REG_FAIL    = 2'd1;
  localparam reg_idx_t REG_CLEANUP = 2'd2;
  localparam reg_idx_t REG_OWN_KEY = 2'd3;

  localparam logic [15:0] RST_ROUND   = 16'd1000;
  localparam logic [15:0] RST_FAIL    = 16'd2000;
  localparam logic [15:0] RST_CLEANUP = 16'd4000;

  typedef struct packed {
    logic [15:0] round_time;
    logic [15:0] fail_time;
    logic [15:0] cleanup_time;
  } cfg_t;

endpackage
`default_nettype wire

>>> rtl/hbfd_if.sv
// Channel interfaces for the heartbeat failure detector.
// Depends on hbfd_pkg for the default field widths.
`default_nettype none
interface hbfd_in_if #(
  parameter int KEY_BITS   = hbfd_pkg::HBFD_KEY_BITS,
  parameter int COUNT_BITS = hbfd_pkg::HBFD_COUNT_BITS
) ();
  logic                  valid;
  logic                  ready;
  logic                  opcode;
  logic [KEY_BITS-1:0]   peer_key;
  logic [COUNT_BITS-1:0] heartbeat_count;
  modport source (output valid, opcode, peer_key, heartbeat_count, input ready);
  modport sink (input valid, opcode, peer_key, heartbeat_count, output ready);
endinterface

interface hbfd_out_if ();
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [5:0] newly_suspected;
  logic [5:0] removed_count;
  logic [5:0] alive_count;
  modport source (output valid, status, newly_suspected, removed_count, alive_count,
                  input ready);
  modport sink (input valid, status, newly_suspected, removed_count, alive_count,
                output ready);
endinterface
`default_nettype wire

>>> rtl/hbfd_cell.sv
// One table cell of the rotating membership ring: a peer entry that moves
// to its neighbor on every shift cycle. No package dependencies.
`default_nettype none
module hbfd_cell #(
  parameter int KEY_BITS   = 16,
  parameter int COUNT_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  shift_en,
  input  wire logic                  d_valid,
  input  wire logic                  d_susp,
  input  wire logic [KEY_BITS-1:0]   d_key,
  input  wire logic [COUNT_BITS-1:0] d_count,
  input  wire logic [31:0]           d_deadline,
  output logic                       q_valid,
  output logic                       q_susp,
  output logic [KEY_BITS-1:0]        q_key,
  output logic [COUNT_BITS-1:0]      q_count,
  output logic [31:0]                q_deadline
);

  logic                  valid_r, susp_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [COUNT_BITS-1:0] count_r;
  logic [31:0]           deadline_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      susp_r  <= 1'b0;
    end else if (shift_en) begin
      valid_r <= d_valid;
      susp_r  <= d_susp;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      key_r      <= d_key;
      count_r    <= d_count;
      deadline_r <= d_deadline;
    end
  end

  assign q_valid    = valid_r;
  assign q_susp     = susp_r;
  assign q_key      = key_r;
  assign q_count    = count_r;
  assign q_deadline = deadline_r;

endmodule
`default_nettype wire

>>> rtl/hbfd_regs.sv
// APB-style configuration registers of the heartbeat failure detector.
// Depends on hbfd_pkg for register codes, reset values and cfg_t.
`default_nettype none
module hbfd_regs #(
  parameter int KEY_BITS = hbfd_pkg::HBFD_KEY_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output hbfd_pkg::cfg_t   cfg,
  output logic [KEY_BITS-1:0] own_key
);

  localparam int OKW = (KEY_BITS < 16) ? KEY_BITS : 16;

  hbfd_pkg::cfg_t        cfg_r;
  logic [KEY_BITS-1:0]   own_key_r;
  hbfd_pkg::reg_idx_t    idx;
  logic                  wr;

  assign idx    = paddr[3:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.round_time   <= hbfd_pkg::RST_ROUND;
      cfg_r.fail_time    <= hbfd_pkg::RST_FAIL;
      cfg_r.cleanup_time <= hbfd_pkg::RST_CLEANUP;
      own_key_r          <= '0;
    end else if (wr) begin
      unique case (idx)
        hbfd_pkg::REG_ROUND:   cfg_r.round_time   <= pwdata[15:0];
        hbfd_pkg::REG_FAIL:    cfg_r.fail_time    <= pwdata[15:0];
        hbfd_pkg::REG_CLEANUP: cfg_r.cleanup_time <= pwdata[15:0];
        hbfd_pkg::REG_OWN_KEY: own_key_r <= KEY_BITS'(pwdata[OKW-1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      hbfd_pkg::REG_ROUND:   prdata = {16'd0, cfg_r.round_time};
      hbfd_pkg::REG_FAIL:    prdata = {16'd0, cfg_r.fail_time};
      hbfd_pkg::REG_CLEANUP: prdata = {16'd0, cfg_r.cleanup_time};
      hbfd_pkg::REG_OWN_KEY: prdata = {16'd0, 16'(own_key_r[OKW-1:0])};
      default:               prdata = '0;
    endcase
  end

  assign cfg     = cfg_r;
  assign own_key = own_key_r;

endmodule
`default_nettype wire

>>> rtl/heartbeat_failure_detector.sv
// Top level of the heartbeat failure detector: a ring of table cells, the
// head processing step, the sequencer and the result register.
// Depends on hbfd_pkg, hbfd_if, hbfd_cell and hbfd_regs.
//
//   Channel   Direction  Handshake        Payload
//   in_if     sink       valid / ready    opcode, peer_key, heartbeat_count
//   out_if    source     valid / ready    status, newly_suspected, removed_count,
//                                         alive_count
//   cfg_*     slave      psel / penable   four 16-bit registers at 4*i
//
// A tick transaction is one pass and a heartbeat is two: the ring rotates
// once past the head step per pass, and a heartbeat needs a lookup pass
// and an update pass.
// Reset is synchronous and empties the table; there is no clearing pass.
// A new transaction is accepted while the previous result waits on out_if.
`default_nettype none
module heartbeat_failure_detector #(
  parameter int TABLE_DEPTH = hbfd_pkg::HBFD_TABLE_DEPTH,
  parameter int KEY_BITS    = hbfd_pkg::HBFD_KEY_BITS,
  parameter int COUNT_BITS  = hbfd_pkg::HBFD_COUNT_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  hbfd_in_if.sink          in_if,
  hbfd_out_if.source       out_if,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int IW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int KW  = (KEY_BITS < 16) ? KEY_BITS : 16;
  localparam int CW  = (COUNT_BITS < 32) ? COUNT_BITS : 32;
  localparam int NW  = hbfd_pkg::CNT_W;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_APPLY = 5'b00100,
    S_TICK  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  hbfd_pkg::cfg_t        cfg;
  logic [KEY_BITS-1:0]   own_key;

  hbfd_regs #(.KEY_BITS(KEY_BITS)) u_regs (
    .clk(clk), .rst_n(rst_n), .psel(cfg_psel), .penable(cfg_penable),
    .pwrite(cfg_pwrite), .paddr(cfg_paddr), .pwdata(cfg_pwdata),
    .prdata(cfg_prdata), .pready(cfg_pready), .cfg(cfg), .own_key(own_key)
  );

  logic                  q_valid [TABLE_DEPTH];
  logic                  q_susp  [TABLE_DEPTH];
  logic [KEY_BITS-1:0]   q_key   [TABLE_DEPTH];
  logic [COUNT_BITS-1:0] q_count [TABLE_DEPTH];
  logic [31:0]           q_dl    [TABLE_DEPTH];
  logic                  d_valid [TABLE_DEPTH];
  logic                  d_susp  [TABLE_DEPTH];
  logic [KEY_BITS-1:0]   d_key   [TABLE_DEPTH];
  logic [COUNT_BITS-1:0] d_count [TABLE_DEPTH];
  logic [31:0]           d_dl    [TABLE_DEPTH];

  state_t                state_r, state_nxt;
  logic [IW-1:0]         idx_r, idx_nxt;
  logic [KEY_BITS-1:0]   key_r;
  logic [COUNT_BITS-1:0] cnt_r;
  logic [31:0]           now_r, now_nxt;
  logic                  hit_r, hit_nxt, free_r, free_nxt;
  logic [IW-1:0]         hit_idx_r, hit_idx_nxt, free_idx_r, free_idx_nxt;
  hbfd_pkg::status_t     status_r, status_nxt;
  logic [NW-1:0]         sus_r, sus_nxt, rem_r, rem_nxt, alive_r, alive_nxt;

  logic                  out_valid_r, out_valid_nxt;
  hbfd_pkg::status_t     out_status_r;
  logic [NW-1:0]         out_sus_r, out_rem_r, out_alive_r;

  logic                  shift_en, last, accept, load_out;
  logic                  p_valid, p_susp;
  logic [COUNT_BITS-1:0] p_count;
  logic [31:0]           p_dl, refresh_dl;

  assign shift_en   = (state_r == S_SCAN) || (state_r == S_APPLY) || (state_r == S_TICK);
  assign last       = (idx_r == IW'(TABLE_DEPTH - 1));
  assign accept     = in_if.valid && in_if.ready;
  assign in_if.ready = (state_r == S_IDLE);
  assign load_out   = (state_r == S_DONE) && (!out_valid_r || out_if.ready);
  assign refresh_dl = now_r + 32'(cfg.round_time);

  // Head step: processes the entry leaving cell 0 before it re-enters the ring.
  always_comb begin
    p_valid      = q_valid[0];
    p_susp       = q_susp[0];
    p_count      = q_count[0];
    p_dl         = q_dl[0];
    hit_nxt      = hit_r;
    hit_idx_nxt  = hit_idx_r;
    free_nxt     = free_r;
    free_idx_nxt = free_idx_r;
    status_nxt   = status_r;
    sus_nxt      = sus_r;
    rem_nxt      = rem_r;
    if (state_r == S_SCAN) begin
      if (q_valid[0]) begin
        if (!hit_r && (q_key[0] == key_r)) begin
          hit_nxt     = 1'b1;
          hit_idx_nxt = idx_r;
        end
      end else if (!free_r) begin
        free_nxt     = 1'b1;
        free_idx_nxt = idx_r;
      end
      if (last && !hit_nxt) begin
        status_nxt = free_nxt ? hbfd_pkg::ST_ADDED : hbfd_pkg::ST_FULL;
      end
    end else if (state_r == S_APPLY) begin
      if (hit_r && (idx_r == hit_idx_r)) begin
        if (cnt_r > q_count[0]) begin
          p_count    = cnt_r;
          p_dl       = refresh_dl;
          p_susp     = 1'b0;
          status_nxt = q_susp[0] ? hbfd_pkg::ST_REVIVE : hbfd_pkg::ST_REFRESH;
        end else begin
          status_nxt = hbfd_pkg::ST_STALE;
        end
      end else if (!hit_r && free_r && (idx_r == free_idx_r)) begin
        p_valid = 1'b1;
        p_susp  = 1'b0;
        p_count = cnt_r;
        p_dl    = refresh_dl;
      end
    end else if (state_r == S_TICK) begin
      if (q_valid[0] && (q_key[0] != own_key)) begin
        if (q_susp[0]) begin
          if (((q_dl[0] + 32'(cfg.cleanup_time)) - now_r) >> 31 != 32'd0) begin
            p_valid = 1'b0;
            p_susp  = 1'b0;
            rem_nxt = rem_r + NW'(1);
          end
        end else if (((q_dl[0] + 32'(cfg.fail_time)) - now_r) >> 31 != 32'd0) begin
          p_susp  = 1'b1;
          p_dl    = refresh_dl;
          sus_nxt = sus_r + NW'(1);
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (i == TABLE_DEPTH - 1) begin
        d_valid[i] = p_valid;
        d_susp[i]  = p_susp;
        d_key[i]   = (state_r == S_APPLY && !hit_r && free_r && idx_r == free_idx_r) ?
                     key_r : q_key[0];
        d_count[i] = p_count;
        d_dl[i]    = p_dl;
      end else begin
        d_valid[i] = q_valid[i+1];
        d_susp[i]  = q_susp[i+1];
        d_key[i]   = q_key[i+1];
        d_count[i] = q_count[i+1];
        d_dl[i]    = q_dl[i+1];
      end
    end
  end

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    hbfd_cell #(.KEY_BITS(KEY_BITS), .COUNT_BITS(COUNT_BITS)) u_cell (
      .clk(clk), .rst_n(rst_n), .shift_en(shift_en),
      .d_valid(d_valid[g]), .d_susp(d_susp[g]), .d_key(d_key[g]),
      .d_count(d_count[g]), .d_deadline(d_dl[g]),
      .q_valid(q_valid[g]), .q_susp(q_susp[g]), .q_key(q_key[g]),
      .q_count(q_count[g]), .q_deadline(q_dl[g])
    );
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = shift_en ? (last ? '0 : idx_r + IW'(1)) : idx_r;
    now_nxt   = now_r;
    alive_nxt = alive_r;
    if ((state_r == S_APPLY || state_r == S_TICK) && p_valid && !p_susp) begin
      alive_nxt = alive_r + NW'(1);
    end
    unique case (state_r)
      S_IDLE: begin
        idx_nxt = '0;
        if (accept) begin
          state_nxt = in_if.opcode ? S_TICK : S_SCAN;
          if (in_if.opcode) begin
            now_nxt = now_r + 32'd1;
          end
        end
      end
      S_SCAN: begin
        if (last) begin
          state_nxt = S_APPLY;
        end
      end
      S_APPLY, S_TICK: begin
        if (last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = load_out ? 1'b1 : (out_if.ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      now_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      now_r       <= now_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key_r    <= KEY_BITS'(in_if.peer_key[KW-1:0]);
      cnt_r    <= COUNT_BITS'(in_if.heartbeat_count[CW-1:0]);
      hit_r    <= 1'b0;
      free_r   <= 1'b0;
      status_r <= hbfd_pkg::ST_TICK;
      sus_r    <= '0;
      rem_r    <= '0;
      alive_r  <= '0;
    end else begin
      hit_r      <= hit_nxt;
      free_r     <= free_nxt;
      hit_idx_r  <= hit_idx_nxt;
      free_idx_r <= free_idx_nxt;
      status_r   <= status_nxt;
      sus_r      <= sus_nxt;
      rem_r      <= rem_nxt;
      alive_r    <= alive_nxt;
    end
    if (load_out) begin
      out_status_r <= status_r;
      out_sus_r    <= sus_r;
      out_rem_r    <= rem_r;
      out_alive_r  <= alive_r;
    end
  end

  assign out_if.valid           = out_valid_r;
  assign out_if.status          = out_status_r;
  assign out_if.newly_suspected = out_sus_r;
  assign out_if.removed_count   = out_rem_r;
  assign out_if.alive_count     = out_alive_r;

`ifndef SYNTHESIS
  a_done_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |-> (idx_r == '0))
    else $error("Ring not back in order at end of pass.");
  a_heartbeat_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != hbfd_pkg::ST_TICK)) |->
      ((out_sus_r == '0) && (out_rem_r == '0)))
    else $error("Heartbeat result carries sweep counts.");
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("Result raised outside the completion step.");
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    shift_en |-> !in_if.ready)
    else $error("Input ready while the ring is rotating.");
`endif

endmodule
`default_nettype wire
